/* rtl/core/taf_pkg.sv */
`timescale 1ns / 1ps
// Shared widths, register indexes and constants of the track acceptance filter.
package taf_pkg;

  localparam int MOM_W      = 21;
  localparam int POS_W      = 21;
  localparam int FRAC_W     = 16;
  localparam int CHG_W      = 3;
  localparam int ZPOS_W     = 15;
  localparam int HALF_W     = 14;
  localparam int CFG_DATA_W = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_MAGNET_Z    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACKER_Z   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRK_HALF_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRK_HALF_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLE_HALF_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLE_HALF_Y = 3'd5;

  localparam logic [ZPOS_W-1:0] RST_MAGNET_Z    = 15'd5000;
  localparam logic [ZPOS_W-1:0] RST_TRACKER_Z   = 15'd9000;
  localparam logic [HALF_W-1:0] RST_TRK_HALF_X  = 14'd3000;
  localparam logic [HALF_W-1:0] RST_TRK_HALF_Y  = 14'd2500;
  localparam logic [HALF_W-1:0] RST_HOLE_HALF_X = 14'd100;
  localparam logic [HALF_W-1:0] RST_HOLE_HALF_Y = 14'd100;

  localparam int DIV_NUM_W = 47;
  localparam int DIV_DEN_W = 22;
  localparam int DIV_LAT   = DIV_NUM_W;

  localparam logic [29:0] SINH2_HI = 30'd657536409;
  localparam logic [18:0] SINH2_LO = 19'd365848;

endpackage

/* rtl/core/taf_div.sv */
`timescale 1ns / 1ps
// Pipelined restoring unsigned divider, one quotient bit per stage.
module taf_div (
  input  logic                             clk,
  input  logic                             en,
  input  logic [taf_pkg::DIV_NUM_W-1:0]    num,
  input  logic [taf_pkg::DIV_DEN_W-1:0]    den,
  output logic [taf_pkg::DIV_NUM_W-1:0]    quo
);
  import taf_pkg::*;

  logic [DIV_DEN_W-1:0] rem_r   [0:DIV_LAT-1];
  logic [DIV_NUM_W-1:0] nq_r    [0:DIV_LAT-1];
  logic [DIV_DEN_W-1:0] den_r   [0:DIV_LAT-1];
  logic [DIV_DEN_W-1:0] rem_nxt [0:DIV_LAT-1];
  logic [DIV_NUM_W-1:0] nq_nxt  [0:DIV_LAT-1];
  logic [DIV_DEN_W-1:0] rem_in  [0:DIV_LAT-1];
  logic [DIV_NUM_W-1:0] nq_in   [0:DIV_LAT-1];
  logic [DIV_DEN_W-1:0] den_in  [0:DIV_LAT-1];
  logic [DIV_DEN_W:0]   trial   [0:DIV_LAT-1];

  always_comb begin
    for (int i = 0; i < DIV_LAT; i++) begin
      rem_in[i] = (i == 0) ? '0  : rem_r[(i == 0) ? 0 : i - 1];
      nq_in[i]  = (i == 0) ? num : nq_r[(i == 0) ? 0 : i - 1];
      den_in[i] = (i == 0) ? den : den_r[(i == 0) ? 0 : i - 1];
      trial[i]  = {rem_in[i], nq_in[i][DIV_NUM_W-1]};
      if (trial[i] >= {1'b0, den_in[i]}) begin
        rem_nxt[i] = DIV_DEN_W'(trial[i] - {1'b0, den_in[i]});
        nq_nxt[i]  = {nq_in[i][DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt[i] = DIV_DEN_W'(trial[i]);
        nq_nxt[i]  = {nq_in[i][DIV_NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        rem_r[i] <= rem_nxt[i];
        nq_r[i]  <= nq_nxt[i];
        den_r[i] <= den_in[i];
      end
    end
  end

  assign quo = nq_r[DIV_LAT-1];

endmodule

/* rtl/core/track_acceptance_filter.sv */
`timescale 1ns / 1ps
// Top level of the track acceptance filter: pseudorapidity window and tracker hit test.
//
// The filter takes one particle per clock while the pipeline does not hold, and returns one
// beat with two flags per particle. The latency is set by the chain of three fully pipelined
// units that each particle passes in order: a 47-stage divider for the slope px/pz that sets
// the magnet kick, a 21-stage integer square root for the kicked pz, and a 47-stage divider
// for the displacement from the magnet to the tracker plane. When the output beat is not
// taken, the whole pipeline holds. Configuration writes reach the datapath through registered scaled copies.
module track_acceptance_filter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // charge, mom_x, mom_y, mom_z, origin_x, origin_y, origin_z, zero fill
  input  logic [taf_pkg::IN_DATA_W-1:0]       in_tdata,
  // invisible
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // in_acceptance, in_downstream, zero fill
  output logic [taf_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  logic                                cfg_we,
  input  logic [taf_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [taf_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import taf_pkg::*;

  localparam int OFS_PX   = CHG_W;
  localparam int OFS_PY   = OFS_PX + MOM_W;
  localparam int OFS_PZ   = OFS_PY + MOM_W;
  localparam int OFS_OX   = OFS_PZ + MOM_W;
  localparam int OFS_OY   = OFS_OX + POS_W;
  localparam int OFS_OZ   = OFS_OY + POS_W;
  localparam int SQ_W     = 42;
  localparam int SQ_STEPS = 21;
  localparam int TM_W     = MOM_W + FRAC_W;
  localparam int TM_LO    = 18;

  localparam int ST_DZ   = 2;
  localparam int ST_MUL  = 3;
  localparam int ST_ACC  = 6;
  localparam int ST_TQ   = 1 + DIV_LAT;
  localparam int ST_XQ   = ST_MUL + DIV_LAT;
  localparam int ST_KICK = ST_TQ + 4;
  localparam int ST_PXK  = ST_TQ + 5;
  localparam int ST_D    = ST_TQ + 7;
  localparam int ST_PZK  = ST_D + SQ_STEPS + 1;
  localparam int ST_P2   = ST_PZK + 1;
  localparam int ST_Q2   = ST_P2 + DIV_LAT;
  localparam int ST_XT   = ST_Q2 + 1;
  localparam int ST_OUT  = ST_XT + 1;

  localparam logic signed [63:0] KQ_BASE = 64'sd1260 <<< FRAC_W;
  localparam logic signed [63:0] KQ_CAP  = 64'sd1400 <<< FRAC_W;
  localparam logic [63:0]        KQ_HALF = 64'd1 << (FRAC_W - 1);
  localparam logic [10:0]        KICK_MAX = 11'd1400;

  function automatic logic [MOM_W-1:0] mag_mom(input logic signed [MOM_W-1:0] v);
    logic signed [MOM_W-1:0] n;
    n = v[MOM_W-1] ? -v : v;
    return n;
  endfunction

  function automatic logic [DIV_NUM_W-1:0] mag_prod(input logic signed [48:0] v);
    logic signed [48:0] n;
    n = v[48] ? -v : v;
    return n[DIV_NUM_W-1:0];
  endfunction

  logic [ZPOS_W-1:0] mag_z_r, trk_z_r;
  logic [HALF_W-1:0] trk_hx_r, trk_hy_r, hole_hx_r, hole_hy_r;
  logic [24:0]        zc1000_r;
  logic signed [26:0] dz2_r;
  logic [23:0]        thx_r, thy_r, bhx_r, bhy_r;

  logic [1:ST_OUT] valid_r;
  logic            adv;

  logic signed [CHG_W-1:0] in_chg;
  logic signed [MOM_W-1:0] in_px, in_py, in_pz;
  logic signed [POS_W-1:0] in_ox, in_oy, in_oz;

  logic                    inv_d  [1:ST_XT];
  logic                    fwd_d  [1:ST_XT];
  logic                    zero_d [1:ST_ACC-1];
  logic signed [CHG_W-1:0] q_d    [1:ST_KICK];
  logic signed [MOM_W-1:0] px_d   [1:ST_KICK];
  logic signed [MOM_W-1:0] py_d   [1:ST_PZK];
  logic signed [MOM_W-1:0] pz_d   [1:ST_MUL];
  logic signed [POS_W-1:0] ox_d   [1:ST_XQ];
  logic signed [POS_W-1:0] oy_d   [1:ST_XQ];
  logic signed [POS_W-1:0] oz_r;

  logic signed [26:0]      dz1_r;
  logic [2*MOM_W-2:0]      sqx_d [ST_DZ:ST_PXK];
  logic [2*MOM_W-2:0]      sqz_d [ST_DZ:ST_PXK];
  logic [2*MOM_W-2:0]      sqy_r;
  logic signed [47:0]      pxdz_r, pydz_r;
  logic [41:0]             pt2_r;
  logic [39:0]             lo_h_r, lo_l_r;
  logic [50:0]             hi_h_r, hi_l_r;
  logic [71:0]             lo5_r, hi5_r, lhs5_r;
  logic                    acc_d [ST_ACC:ST_XT];
  logic                    sx_d  [ST_MUL+1:ST_XQ];
  logic                    sy_d  [ST_MUL+1:ST_XQ];

  logic [DIV_NUM_W-1:0]    qt, qx, qy, q2x, q2y;
  logic signed [47:0]      t49_r, t50_r;
  logic [37:0]             pp_hh_r;
  logic [36:0]             pp_hl_r;
  logic [35:0]             pp_ll_r;
  logic [47:0]             t2_r;
  logic [63:0]             sq64;
  logic signed [63:0]      t_ext, kq_nxt, kq_r;
  logic [63:0]             kc;
  logic [10:0]             kick_r;
  logic signed [14:0]      qk;
  logic signed [21:0]      pxk_nxt;
  logic signed [21:0]      pxk_d [ST_PXK:ST_PZK];
  logic [21:0]             pxk_mag;
  logic [43:0]             a_r, b_r;
  logic [SQ_W-1:0]         d_r;
  logic                    ok_d [ST_D:ST_XT];

  logic [SQ_W-1:0]         sqx_r [0:SQ_STEPS-1];
  logic [SQ_W-1:0]         sqr_r [0:SQ_STEPS-1];
  logic [SQ_W-1:0]         sq_xin [0:SQ_STEPS-1];
  logic [SQ_W-1:0]         sq_rin [0:SQ_STEPS-1];
  logic [SQ_W-1:0]         sq_xn  [0:SQ_STEPS-1];
  logic [SQ_W-1:0]         sq_rn  [0:SQ_STEPS-1];
  logic [SQ_W:0]           sq_bit [0:SQ_STEPS-1];
  logic [SQ_W:0]           sq_sum [0:SQ_STEPS-1];

  logic [DIV_DEN_W-1:0]    pzk_r, pzk2_r;
  logic signed [48:0]      p2x_r, p2y_r;
  logic                    s2x_d [ST_P2+1:ST_Q2];
  logic                    s2y_d [ST_P2+1:ST_Q2];
  logic signed [48:0]      xm_nxt, ym_nxt;
  logic signed [48:0]      xm_d [ST_XQ+1:ST_Q2];
  logic signed [48:0]      ym_d [ST_XQ+1:ST_Q2];
  logic signed [49:0]      xt_r, yt_r;
  logic                    in_trk, in_hole;
  logic                    acc_o_r, dn_o_r;

  assign in_chg = $signed(in_tdata[CHG_W-1:0]);
  assign in_px  = $signed(in_tdata[OFS_PX +: MOM_W]);
  assign in_py  = $signed(in_tdata[OFS_PY +: MOM_W]);
  assign in_pz  = $signed(in_tdata[OFS_PZ +: MOM_W]);
  assign in_ox  = $signed(in_tdata[OFS_OX +: POS_W]);
  assign in_oy  = $signed(in_tdata[OFS_OY +: POS_W]);
  assign in_oz  = $signed(in_tdata[OFS_OZ +: POS_W]);

  assign adv        = !valid_r[ST_OUT] || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = valid_r[ST_OUT];
  assign out_tdata  = {{(OUT_DATA_W-2){1'b0}}, dn_o_r, acc_o_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_z_r   <= RST_MAGNET_Z;
      trk_z_r   <= RST_TRACKER_Z;
      trk_hx_r  <= RST_TRK_HALF_X;
      trk_hy_r  <= RST_TRK_HALF_Y;
      hole_hx_r <= RST_HOLE_HALF_X;
      hole_hy_r <= RST_HOLE_HALF_Y;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_MAGNET_Z:    mag_z_r   <= cfg_data[ZPOS_W-1:0];
        CFG_TRACKER_Z:   trk_z_r   <= cfg_data[ZPOS_W-1:0];
        CFG_TRK_HALF_X:  trk_hx_r  <= cfg_data[HALF_W-1:0];
        CFG_TRK_HALF_Y:  trk_hy_r  <= cfg_data[HALF_W-1:0];
        CFG_HOLE_HALF_X: hole_hx_r <= cfg_data[HALF_W-1:0];
        CFG_HOLE_HALF_Y: hole_hy_r <= cfg_data[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    zc1000_r <= 25'(mag_z_r) * 25'd1000;
    dz2_r    <= (27'($signed({1'b0, trk_z_r})) - 27'($signed({1'b0, mag_z_r}))) * 27'sd1000;
    thx_r    <= 24'(trk_hx_r) * 24'd1000;
    thy_r    <= 24'(trk_hy_r) * 24'd1000;
    bhx_r    <= 24'(hole_hx_r) * 24'd1000;
    bhy_r    <= 24'(hole_hy_r) * 24'd1000;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (adv) begin
      valid_r <= {in_tvalid, valid_r[1:ST_OUT-1]};
    end
  end

  taf_div u_div_t (
    .clk (clk),
    .en  (adv),
    .num (DIV_NUM_W'({mag_mom(px_d[1]), {FRAC_W{1'b0}}})),
    .den ({1'b0, pz_d[1]}),
    .quo (qt)
  );

  taf_div u_div_x (
    .clk (clk),
    .en  (adv),
    .num (mag_prod(49'(pxdz_r))),
    .den ({1'b0, pz_d[ST_MUL]}),
    .quo (qx)
  );

  taf_div u_div_y (
    .clk (clk),
    .en  (adv),
    .num (mag_prod(49'(pydz_r))),
    .den ({1'b0, pz_d[ST_MUL]}),
    .quo (qy)
  );

  taf_div u_div_px (
    .clk (clk),
    .en  (adv),
    .num (mag_prod(p2x_r)),
    .den (pzk2_r),
    .quo (q2x)
  );

  taf_div u_div_py (
    .clk (clk),
    .en  (adv),
    .num (mag_prod(p2y_r)),
    .den (pzk2_r),
    .quo (q2y)
  );

  always_comb begin
    sq64   = (64'(pp_hh_r) << (2 * TM_LO)) + (64'(pp_hl_r) << (TM_LO + 1)) + 64'(pp_ll_r);
    t_ext  = 64'(t50_r);
    kq_nxt = $signed(64'(t2_r)) * 64'sd2200 - t_ext * 64'sd5 + KQ_BASE;
    kc     = kq_r[63] ? 64'd0 : ((kq_r > KQ_CAP) ? 64'(KQ_CAP) : 64'(kq_r));
    qk     = q_d[ST_KICK] * $signed({1'b0, kick_r});
    pxk_nxt = 22'(px_d[ST_KICK]) + 22'(qk);
    pxk_mag = pxk_d[ST_PXK][21] ? 22'(-pxk_d[ST_PXK]) : 22'(pxk_d[ST_PXK]);
    xm_nxt = 49'(ox_d[ST_XQ]) + (sx_d[ST_XQ] ? -$signed({2'b0, qx}) : $signed({2'b0, qx}));
    ym_nxt = 49'(oy_d[ST_XQ]) + (sy_d[ST_XQ] ? -$signed({2'b0, qy}) : $signed({2'b0, qy}));
    in_trk = (xt_r < $signed({26'b0, thx_r})) && (xt_r > -$signed({26'b0, thx_r})) &&
             (yt_r < $signed({26'b0, thy_r})) && (yt_r > -$signed({26'b0, thy_r}));
    in_hole = (xt_r < $signed({26'b0, bhx_r})) && (xt_r > -$signed({26'b0, bhx_r})) &&
              (yt_r < $signed({26'b0, bhy_r})) && (yt_r > -$signed({26'b0, bhy_r}));
  end

  always_comb begin
    for (int i = 0; i < SQ_STEPS; i++) begin
      sq_xin[i] = (i == 0) ? d_r : sqx_r[(i == 0) ? 0 : i - 1];
      sq_rin[i] = (i == 0) ? '0  : sqr_r[(i == 0) ? 0 : i - 1];
      sq_bit[i] = (SQ_W + 1)'(1) << (SQ_W - 2 - 2 * i);
      sq_sum[i] = {1'b0, sq_rin[i]} + sq_bit[i];
      if ({1'b0, sq_xin[i]} >= sq_sum[i]) begin
        sq_xn[i] = SQ_W'({1'b0, sq_xin[i]} - sq_sum[i]);
        sq_rn[i] = (sq_rin[i] >> 1) + SQ_W'(sq_bit[i]);
      end else begin
        sq_xn[i] = sq_xin[i];
        sq_rn[i] = sq_rin[i] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      inv_d[1]  <= in_tuser;
      fwd_d[1]  <= !in_pz[MOM_W-1] && (in_pz != '0);
      zero_d[1] <= (in_px == '0) && (in_py == '0) && (in_pz == '0);
      q_d[1]    <= in_chg;
      px_d[1]   <= in_px;
      py_d[1]   <= in_py;
      pz_d[1]   <= in_pz;
      ox_d[1]   <= in_ox;
      oy_d[1]   <= in_oy;
      oz_r      <= in_oz;
      for (int k = 2; k <= ST_XT; k++) begin
        inv_d[k] <= inv_d[k-1];
        fwd_d[k] <= fwd_d[k-1];
      end
      for (int k = 2; k < ST_ACC; k++) zero_d[k] <= zero_d[k-1];
      for (int k = 2; k <= ST_KICK; k++) begin
        q_d[k]  <= q_d[k-1];
        px_d[k] <= px_d[k-1];
      end
      for (int k = 2; k <= ST_PZK; k++) py_d[k] <= py_d[k-1];
      for (int k = 2; k <= ST_MUL; k++) pz_d[k] <= pz_d[k-1];
      for (int k = 2; k <= ST_XQ; k++) begin
        ox_d[k] <= ox_d[k-1];
        oy_d[k] <= oy_d[k-1];
      end

      dz1_r        <= $signed({2'b0, zc1000_r}) - 27'(oz_r);
      sqx_d[ST_DZ] <= (2*MOM_W-1)'(mag_mom(px_d[1])) * (2*MOM_W-1)'(mag_mom(px_d[1]));
      sqy_r        <= (2*MOM_W-1)'(mag_mom(py_d[1])) * (2*MOM_W-1)'(mag_mom(py_d[1]));
      sqz_d[ST_DZ] <= (2*MOM_W-1)'(mag_mom(pz_d[1])) * (2*MOM_W-1)'(mag_mom(pz_d[1]));
      for (int k = ST_DZ + 1; k <= ST_PXK; k++) begin
        sqx_d[k] <= sqx_d[k-1];
        sqz_d[k] <= sqz_d[k-1];
      end

      pxdz_r <= 48'(px_d[ST_DZ]) * 48'(dz1_r);
      pydz_r <= 48'(py_d[ST_DZ]) * 48'(dz1_r);
      pt2_r  <= 42'(sqx_d[ST_DZ]) + 42'(sqy_r);

      lo_h_r <= 40'(SINH2_LO) * 40'(pt2_r[41:21]);
      lo_l_r <= 40'(SINH2_LO) * 40'(pt2_r[20:0]);
      hi_h_r <= 51'(SINH2_HI) * 51'(pt2_r[41:21]);
      hi_l_r <= 51'(SINH2_HI) * 51'(pt2_r[20:0]);

      lo5_r  <= (72'(lo_h_r) << 21) + 72'(lo_l_r);
      hi5_r  <= (72'(hi_h_r) << 21) + 72'(hi_l_r);
      lhs5_r <= 72'(sqz_d[ST_MUL+1]) << FRAC_W;

      acc_d[ST_ACC] <= zero_d[ST_ACC-1] ||
                       (fwd_d[ST_ACC-1] && (lo5_r <= lhs5_r) && (lhs5_r <= hi5_r));
      for (int k = ST_ACC + 1; k <= ST_XT; k++) acc_d[k] <= acc_d[k-1];

      sx_d[ST_MUL+1] <= pxdz_r[47];
      sy_d[ST_MUL+1] <= pydz_r[47];
      for (int k = ST_MUL + 2; k <= ST_XQ; k++) begin
        sx_d[k] <= sx_d[k-1];
        sy_d[k] <= sy_d[k-1];
      end

      t49_r   <= px_d[ST_TQ][MOM_W-1] ? -$signed({1'b0, qt}) : $signed({1'b0, qt});
      pp_hh_r <= 38'(qt[TM_W-1:TM_LO]) * 38'(qt[TM_W-1:TM_LO]);
      pp_hl_r <= 37'(qt[TM_W-1:TM_LO]) * 37'(qt[TM_LO-1:0]);
      pp_ll_r <= 36'(qt[TM_LO-1:0]) * 36'(qt[TM_LO-1:0]);
      t50_r   <= t49_r;
      t2_r    <= sq64[63:FRAC_W];
      kq_r    <= kq_nxt;
      kick_r  <= 11'((kc + KQ_HALF) >> FRAC_W);
      pxk_d[ST_PXK] <= pxk_nxt;
      for (int k = ST_PXK + 1; k <= ST_PZK; k++) pxk_d[k] <= pxk_d[k-1];

      a_r <= 44'(sqx_d[ST_PXK]) + 44'(sqz_d[ST_PXK]);
      b_r <= 44'(pxk_mag) * 44'(pxk_mag);
      d_r <= SQ_W'(a_r - b_r);
      ok_d[ST_D] <= b_r < a_r;
      for (int k = ST_D + 1; k <= ST_XT; k++) ok_d[k] <= ok_d[k-1];

      for (int i = 0; i < SQ_STEPS; i++) begin
        sqx_r[i] <= sq_xn[i];
        sqr_r[i] <= sq_rn[i];
      end
      pzk_r <= DIV_DEN_W'(sqr_r[SQ_STEPS-1]) +
               DIV_DEN_W'(sqx_r[SQ_STEPS-1] > sqr_r[SQ_STEPS-1]);

      pzk2_r <= pzk_r;
      p2x_r  <= 49'(pxk_d[ST_PZK]) * 49'(dz2_r);
      p2y_r  <= 49'(py_d[ST_PZK]) * 49'(dz2_r);
      s2x_d[ST_P2+1] <= p2x_r[48];
      s2y_d[ST_P2+1] <= p2y_r[48];
      for (int k = ST_P2 + 2; k <= ST_Q2; k++) begin
        s2x_d[k] <= s2x_d[k-1];
        s2y_d[k] <= s2y_d[k-1];
      end

      xm_d[ST_XQ+1] <= xm_nxt;
      ym_d[ST_XQ+1] <= ym_nxt;
      for (int k = ST_XQ + 2; k <= ST_Q2; k++) begin
        xm_d[k] <= xm_d[k-1];
        ym_d[k] <= ym_d[k-1];
      end

      xt_r <= 50'(xm_d[ST_Q2]) +
              (s2x_d[ST_Q2] ? -$signed({3'b0, q2x}) : $signed({3'b0, q2x}));
      yt_r <= 50'(ym_d[ST_Q2]) +
              (s2y_d[ST_Q2] ? -$signed({3'b0, q2y}) : $signed({3'b0, q2y}));

      acc_o_r <= inv_d[ST_XT] || acc_d[ST_XT];
      dn_o_r  <= inv_d[ST_XT] ||
                 (acc_d[ST_XT] && fwd_d[ST_XT] && ok_d[ST_XT] && in_trk && !in_hole);
    end
  end

  a_accept_enters : assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> valid_r[1])
    else $error("accepted beat did not enter the pipeline");

  a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(valid_r))
    else $error("pipeline moved during a stall");

  a_down_implies_acc : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tdata[1] || out_tdata[0]))
    else $error("downstream flag without acceptance flag");

  a_kick_capped : assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[ST_KICK] |-> (kick_r <= KICK_MAX))
    else $error("magnet kick above cap");

  a_sqrt_arg : assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[ST_D] && ok_d[ST_D] |-> (d_r != '0))
    else $error("square root argument zero for a kept particle");

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// Track acceptance filter testbench: directed and random particles against a predictor of both flags.
module tb;
  import taf_pkg::*;

  typedef struct {
    bit                       invisible;
    logic signed [CHG_W-1:0]  charge;
    logic signed [MOM_W-1:0]  px, py, pz;
    logic signed [POS_W-1:0]  ox, oy, oz;
  } particle_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, in_tuser;
  logic [IN_DATA_W-1:0] in_tdata;
  logic out_tvalid, out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  track_acceptance_filter u_dut (.*);

  longint unsigned reg_zc, reg_zt, reg_thx, reg_thy, reg_hhx, reg_hhy;
  particle_t pending_particles[$];
  logic [1:0] expected_flags[$];
  particle_t cur_particle;
  int send_idle_pct, recv_stall_pct;
  int errors = 0;
  int checked = 0;
  int n_accept = 0;
  int n_down = 0;
  bit hold_req, hold_seen;
  int hold_left;

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  function automatic longint unsigned from_q24(longint unsigned x);
    return (((x << 1) >> (24 - FRAC_W)) + 1) >> 1;
  endfunction

  function automatic longint unsigned abs64(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned root_nearest(longint unsigned v);
    longint unsigned r, b, x;
    r = 0; b = 64'd1 << 62; x = v;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    if (v - r * r > r) r++;
    return r;
  endfunction

  function automatic bit eta_window(longint px, longint py, longint pz);
    logic [127:0] pt2, lhs, k;
    if (px == 0 && py == 0 && pz == 0) return 1'b1;
    if (pz <= 0) return 1'b0;
    pt2 = 128'(abs64(px) * abs64(px) + abs64(py) * abs64(py));
    lhs = 128'(abs64(pz) * abs64(pz)) << FRAC_W;
    k = 128'(from_q24(64'd93657128)) * pt2;
    if (k > lhs) return 1'b0;
    k = 128'(from_q24(64'd168329320671)) * pt2;
    return lhs <= k;
  endfunction

  function automatic bit reaches_tracker(particle_t p);
    longint one, q, px, py, pz, t, t2, kq, kick, pxk, pzk, dz1, dz2, xm, ym, xt, yt;
    longint unsigned tt, a, b, ax, ay;
    bit in_t, in_b;
    one = 64'sd1 << FRAC_W;
    q = longint'(p.charge); px = longint'(p.px); py = longint'(p.py); pz = longint'(p.pz);
    if (pz <= 0) return 1'b0;
    t = (px * one) / pz;
    tt = t * t;
    t2 = longint'(tt >> FRAC_W);
    kq = 2200 * t2 - 5 * t + 1260 * one;
    if (kq > 1400 * one) kq = 1400 * one;
    if (kq < 0) kq = 0;
    kick = longint'((longint'(kq) + (64'sd1 << (FRAC_W - 1))) >>> FRAC_W);
    pxk = px + q * kick;
    a = abs64(px) * abs64(px) + abs64(pz) * abs64(pz);
    b = abs64(pxk) * abs64(pxk);
    if (b >= a) return 1'b0;
    pzk = longint'(root_nearest(a - b));
    dz1 = longint'(reg_zc) * 1000 - longint'(p.oz);
    xm = longint'(p.ox) + (px * dz1) / pz;
    ym = longint'(p.oy) + (py * dz1) / pz;
    dz2 = (longint'(reg_zt) - longint'(reg_zc)) * 1000;
    xt = xm + (pxk * dz2) / pzk;
    yt = ym + (py * dz2) / pzk;
    ax = abs64(xt); ay = abs64(yt);
    in_t = ax < reg_thx * 1000 && ay < reg_thy * 1000;
    in_b = ax < reg_hhx * 1000 && ay < reg_hhy * 1000;
    return in_t && !in_b;
  endfunction

  function automatic logic [1:0] predict_flags(particle_t p);
    bit acc;
    if (p.invisible) return 2'b11;
    acc = eta_window(longint'(p.px), longint'(p.py), longint'(p.pz));
    return {acc && reaches_tracker(p), acc};
  endfunction

  function automatic particle_t make_particle(longint px, longint py, longint pz,
                                              int q, bit inv);
    particle_t p;
    p.invisible = inv; p.charge = q[2:0];
    p.px = px[20:0]; p.py = py[20:0]; p.pz = pz[20:0];
    p.ox = $signed(21'($urandom_range(4000))) - 21'sd2000;
    p.oy = $signed(21'($urandom_range(4000))) - 21'sd2000;
    p.oz = $signed(21'($urandom_range(200000))) - 21'sd100000;
    return p;
  endfunction

  function automatic particle_t random_particle();
    particle_t p;
    longint pz, px, py;
    int sel;
    sel = $urandom_range(99);
    if (sel < 20) begin
      p.invisible = 1'($urandom_range(1)); p.charge = CHG_W'($urandom);
      p.px = MOM_W'($urandom); p.py = MOM_W'($urandom); p.pz = MOM_W'($urandom);
      p.ox = POS_W'($urandom); p.oy = POS_W'($urandom); p.oz = POS_W'($urandom);
      return p;
    end
    pz = longint'($urandom_range(1048575, 50));
    px = pz * $urandom_range(500) / 1000;
    py = pz * $urandom_range(500) / 1000;
    if ($urandom_range(1)) px = -px;
    if ($urandom_range(1)) py = -py;
    sel = $urandom_range(19);
    p = make_particle(px, py, pz, sel == 0 ? -4 : sel == 1 ? 3 : $urandom_range(4) - 2,
                      $urandom_range(19) == 0);
    return p;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
    case (idx)
      CFG_MAGNET_Z:    reg_zc  = 64'(val);
      CFG_TRACKER_Z:   reg_zt  = 64'(val);
      CFG_TRK_HALF_X:  reg_thx = 64'(val[HALF_W-1:0]);
      CFG_TRK_HALF_Y:  reg_thy = 64'(val[HALF_W-1:0]);
      CFG_HOLE_HALF_X: reg_hhx = 64'(val[HALF_W-1:0]);
      CFG_HOLE_HALF_Y: reg_hhy = 64'(val[HALF_W-1:0]);
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(int setting);
    logic [CFG_DATA_W-1:0] v[6];
    case (setting)
      0: v = '{RST_MAGNET_Z, RST_TRACKER_Z, 15'(RST_TRK_HALF_X), 15'(RST_TRK_HALF_Y),
               15'(RST_HOLE_HALF_X), 15'(RST_HOLE_HALF_Y)};
      1: v = '{15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0};
      2: v = '{15'd20000, 15'd20000, 15'd10000, 15'd10000, 15'd0, 15'd0};
      3: v = '{15'h7FFF, 15'h7FFF, 15'h3FFF, 15'h3FFF, 15'h3FFF, 15'h3FFF};
      4: v = '{15'd9000, 15'd2000, 15'd5000, 15'd5000, 15'd10000, 15'd10000};
      default: v = '{15'($urandom_range(20000)), 15'($urandom_range(20000)),
                     15'($urandom_range(10000)), 15'($urandom_range(10000)),
                     15'($urandom_range(500)), 15'($urandom_range(500))};
    endcase
    write_reg(CFG_MAGNET_Z, v[0]);
    write_reg(CFG_TRACKER_Z, v[1]);
    write_reg(CFG_TRK_HALF_X, v[2]);
    write_reg(CFG_TRK_HALF_Y, v[3]);
    write_reg(CFG_HOLE_HALF_X, v[4]);
    write_reg(CFG_HOLE_HALF_Y, v[5]);
    repeat (2) @(posedge clk);
  endtask

  task automatic drain();
    while (pending_particles.size() != 0 || in_tvalid || expected_flags.size() != 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // Driver: holds the current beat until taken, then loads the next one or idles.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tuser  <= 1'b0;
      in_tdata  <= '0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) expected_flags.push_back(predict_flags(cur_particle));
      if (pending_particles.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_particle = pending_particles.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= cur_particle.invisible;
        in_tdata  <= {7'd0, cur_particle.oz, cur_particle.oy, cur_particle.ox,
                      cur_particle.pz, cur_particle.py, cur_particle.px, cur_particle.charge};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_seen  <= 1'b0;
      hold_left  <= 0;
      out_tready <= 1'b0;
    end else if (hold_req && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_left <= 600;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  // Monitor: every output beat is checked against the oldest prediction.
  always @(posedge clk) begin
    logic [1:0] exp_f;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_flags.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected beat: flags %b", out_tdata[1:0]);
      end else begin
        exp_f = expected_flags.pop_front();
        checked++;
        n_accept += int'(exp_f[0]);
        n_down += int'(exp_f[1]);
        if (out_tdata !== {6'd0, exp_f}) begin
          errors++;
          if (errors <= 10)
            $display("Mismatch on beat %0d: acceptance exp %b got %b, downstream exp %b got %b",
                     checked, exp_f[0], out_tdata[0], exp_f[1], out_tdata[1]);
        end
      end
    end
  end

  initial begin
    #(20 * 2000000);
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_n = 1'b0; cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
    hold_req = 1'b0;
    send_idle_pct = 0; recv_stall_pct = 0;
    reg_zc = 64'(RST_MAGNET_Z); reg_zt = 64'(RST_TRACKER_Z); reg_thx = 64'(RST_TRK_HALF_X);
    reg_thy = 64'(RST_TRK_HALF_Y); reg_hhx = 64'(RST_HOLE_HALF_X);
    reg_hhy = 64'(RST_HOLE_HALF_Y);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed particles: special cases and field extremes.
    pending_particles.push_back(make_particle(0, 0, 0, 1, 0));
    pending_particles.push_back(make_particle(1000, 200, -5000, 1, 0));
    pending_particles.push_back(make_particle(1000, 200, 0, -1, 0));
    pending_particles.push_back(make_particle(0, 0, 300000, 1, 0));
    pending_particles.push_back(make_particle(10, 0, 100, 2, 0));
    pending_particles.push_back(make_particle(-10, 0, 100, -2, 0));
    pending_particles.push_back(make_particle(5000, 3000, 100000, -4, 0));
    pending_particles.push_back(make_particle(5000, 3000, 100000, 3, 0));
    pending_particles.push_back(make_particle(0, 0, 0, 0, 1));
    pending_particles.push_back(make_particle(-1048576, -1048576, -1048576, -4, 1));
    pending_particles.push_back(make_particle(1048575, 1048575, 1048575, 3, 0));
    pending_particles.push_back(make_particle(-1048576, -1048576, 1048575, -4, 0));
    pending_particles.push_back(make_particle(1048575, 0, 1, 2, 0));
    pending_particles.push_back(make_particle(100000, 0, 1048575, 1, 0));
    pending_particles.push_back(make_particle(0, -200000, 1048575, -1, 0));
    begin
      particle_t p;
      p = make_particle(2000, 1000, 50000, 1, 0);
      p.ox = 21'sh0FFFFF; p.oy = 21'sh100000; p.oz = 21'sh0FFFFF;
      pending_particles.push_back(p);
      p.ox = 21'sh100000; p.oy = 21'sh0FFFFF; p.oz = 21'sh100000;
      pending_particles.push_back(p);
    end
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      set_config(ph);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      for (int i = 0; i < 200; i++) pending_particles.push_back(random_particle());
      if (ph == 4) hold_req = 1'b1;
      drain();
    end

    $display("Checked %0d particles over eight register settings and four idle patterns.",
             checked);
    $display("Predicted in acceptance: %0d, reaching the tracker: %0d.", n_accept, n_down);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches in total.", errors);
      $display("Verification failed");
    end
    $finish;
  end
endmodule
